// ===== rtl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the restoring divider
// Word layouts, operand width and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
    logic                  cache_hit;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request operands
    logic start;     // clear the partial remainder and quotient
    logic step;      // one trial subtraction
    logic hit_out;   // send the cached results
    logic miss_out;  // send the fresh results and refill the cache
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // operands match the cached pair
  } sts_t;

endpackage

// ===== rtl/rdc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath: operand, remainder, cache and result registers
// Performs one restoring-division step per command and holds the one-entry
// result cache together with the outgoing result register.
// ----------------------------------------------------------------------------
module rdc_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rdc_pkg::req_t req,
  input  rdc_pkg::cmd_t cmd,
  output rdc_pkg::sts_t sts,
  output rdc_pkg::rsp_t rsp
);

  logic [rdc_pkg::DATA_WIDTH-1:0] op_dividend;
  logic [rdc_pkg::DATA_WIDTH-1:0] op_divisor;
  logic [rdc_pkg::DATA_WIDTH-1:0] bits;
  logic [rdc_pkg::DATA_WIDTH-1:0] rem;
  logic [rdc_pkg::DATA_WIDTH-1:0] quo;
  logic [rdc_pkg::DATA_WIDTH-1:0] last_dividend;
  logic [rdc_pkg::DATA_WIDTH-1:0] last_divisor;
  logic [rdc_pkg::DATA_WIDTH-1:0] last_quotient;
  logic [rdc_pkg::DATA_WIDTH-1:0] last_remainder;

  logic [rdc_pkg::DATA_WIDTH:0]   trial;
  logic [rdc_pkg::DATA_WIDTH-1:0] diff;
  logic                           take;
  logic [rdc_pkg::DATA_WIDTH-1:0] rem_next;
  logic [rdc_pkg::DATA_WIDTH-1:0] quo_next;

  // The shifted remainder keeps its carry-out as an extra top bit, so the
  // compare against the divisor is exact.
  always_comb begin
    trial    = {rem, bits[rdc_pkg::DATA_WIDTH-1]};
    diff     = trial[rdc_pkg::DATA_WIDTH-1:0] - op_divisor;
    take     = (trial >= {1'b0, op_divisor});
    rem_next = take ? diff : trial[rdc_pkg::DATA_WIDTH-1:0];
    quo_next = {quo[rdc_pkg::DATA_WIDTH-2:0], take};
  end

  assign sts.hit = (op_dividend == last_dividend) && (op_divisor == last_divisor);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_dividend <= req.dividend;
      op_divisor  <= req.divisor;
    end
    if (cmd.start) begin
      rem  <= '0;
      quo  <= '0;
      bits <= op_dividend;
    end else if (cmd.step) begin
      rem  <= rem_next;
      quo  <= quo_next;
      bits <= {bits[rdc_pkg::DATA_WIDTH-2:0], 1'b0};
    end
    if (cmd.hit_out) begin
      rsp.quotient  <= last_quotient;
      rsp.remainder <= last_remainder;
      rsp.cache_hit <= 1'b1;
    end else if (cmd.miss_out) begin
      rsp.quotient  <= quo_next;
      rsp.remainder <= rem_next;
      rsp.cache_hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_dividend  <= '0;
      last_divisor   <= '0;
      last_quotient  <= '0;
      last_remainder <= '0;
    end else if (cmd.miss_out) begin
      last_dividend  <= op_dividend;
      last_divisor   <= op_divisor;
      last_quotient  <= quo_next;
      last_remainder <= rem_next;
    end
  end

endmodule

// ===== rtl/rdc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl: sequencer of the restoring divider
// Accepts one request at a time, checks the cache, counts the division
// steps and owns the valid bit of the result register.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  rdc_pkg::sts_t sts,
  output rdc_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam logic [rdc_pkg::CNT_W-1:0] LAST_STEP =
    rdc_pkg::CNT_W'(rdc_pkg::DATA_WIDTH - 1);

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [rdc_pkg::CNT_W-1:0] count;
  logic [rdc_pkg::CNT_W-1:0] count_next;
  logic                      out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          if (out_free) begin
            cmd.hit_out = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          count_next = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (count == LAST_STEP) begin
          if (out_free) begin
            cmd.step     = 1'b1;
            cmd.miss_out = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.hit_out || cmd.miss_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/restoring_divider_with_result_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_divider_with_result_cache_top: unsigned divider with result cache
// 32-bit unsigned restoring division, one quotient bit per cycle (the last one
// waits for a free output), caching the last operand pair and its results.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   dividend, divisor
//   rsp      out        rsp_valid/rsp_stall   quotient, remainder, cache_hit
//
// A request is taken in an idle cycle and compared with the cached pair in the
// next; a hit goes to the result register from the compare state once that
// register is free. A miss runs 32 trial subtractions, one quotient bit each;
// its last step writes the result and refills the cache, then the block idles.
// Reset clears the control state and the cache, so 0/0 right after reset hits.
// A stalled result stays put; the next request is still taken and only its
// final write waits for the output register.
//
module restoring_divider_with_result_cache_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rdc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rdc_pkg::rsp_t rsp
);

  rdc_pkg::cmd_t cmd;
  rdc_pkg::sts_t sts;

  // The controller sequences compare, division steps and result handoff.
  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds operands, partial results, the cache and the output.
  rdc_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== test/tb_restoring_divider_with_result_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restoring_divider_with_result_cache_top: self-checking divider bench
// Drives dividend/divisor words through a short table of corner cases and
// then a long random stream, predicts every quotient, remainder and cache
// hit in the bench, and checks each result word in order.
// ----------------------------------------------------------------------------
module tb_restoring_divider_with_result_cache_top;

  localparam int DW          = rdc_pkg::DATA_WIDTH;
  localparam int RANDOM_WORDS = 850;
  // The drain after the last result allows for a little more than one full
  // division.
  localparam int DRAIN_CYCLES = 40;
  // Slowest correct run: every word a miss, the longest sender gap and the
  // longest receiver stall for each of 872 words, plus the long hold-off;
  // the limit is several times that.
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int MAX_REPORTS  = 10;

  localparam logic [DW-1:0] ALL_ONES = '1;
  localparam logic [DW-1:0] TOP_BIT  = {1'b1, {(DW-1){1'b0}}};

  // One row of the directed table. When known is set, want holds a result
  // typed in by hand; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic          known;
    rdc_pkg::req_t stim;
    rdc_pkg::rsp_t want;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  rdc_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_stall;
  rdc_pkg::rsp_t  rsp;

  // The bench's own copy of the one-entry result cache.
  logic [DW-1:0] cached_dividend;
  logic [DW-1:0] cached_divisor;
  logic [DW-1:0] cached_quotient;
  logic [DW-1:0] cached_remainder;

  rdc_pkg::rsp_t pending_results[$];
  rdc_pkg::req_t last_offered;

  int  mismatches;
  int  results_seen;
  int  hits_seen;
  int  zero_divisors;
  int  words_accepted;
  int  input_held_cycles;
  int  cycle_count;
  bit  sender_quiet;

  restoring_divider_with_result_cache_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog ends a run that hangs, whatever the other processes do.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Restoring division, most significant bit first, one trial subtraction
  // per quotient bit. The bit shifted out of the partial remainder acts as
  // a carry: when it is set the trial always succeeds, so the compare is in
  // effect done at full width plus one. A zero divisor lets every trial
  // succeed, which gives an all-ones quotient and the dividend as remainder.
  // A word that matches the cached pair returns the cached results.
  function automatic rdc_pkg::rsp_t predict_division(input rdc_pkg::req_t w);
    rdc_pkg::rsp_t res;
    logic [DW-1:0] part;
    logic          carry;
    res.cache_hit = (w.dividend == cached_dividend) && (w.divisor == cached_divisor);
    if (!res.cache_hit) begin
      part            = '0;
      cached_quotient = '0;
      for (int i = DW - 1; i >= 0; i--) begin
        carry = part[DW-1];
        part  = {part[DW-2:0], w.dividend[i]};
        if (carry || part >= w.divisor) begin
          part               = part - w.divisor;
          cached_quotient[i] = 1'b1;
        end
      end
      cached_remainder = part;
      cached_dividend  = w.dividend;
      cached_divisor   = w.divisor;
    end
    res.quotient  = cached_quotient;
    res.remainder = cached_remainder;
    return res;
  endfunction

  function automatic dir_row_t dir_row(input logic known,
                                       input logic [DW-1:0] n, d, q, r,
                                       input logic hit);
    dir_row_t row;
    row.known          = known;
    row.stim.dividend  = n;
    row.stim.divisor   = d;
    row.want.quotient  = q;
    row.want.remainder = r;
    row.want.cache_hit = hit;
    return row;
  endfunction

  // Most gaps are short, a few are long, and in quiet stretches there are
  // none at all so that words arrive back to back.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random operands, weighted toward the cases that exercise the cache and
  // the corners of the division; about a fifth are fully random.
  function automatic rdc_pkg::req_t random_operands();
    rdc_pkg::req_t w;
    int            roll;
    logic [DW-1:0] corner [5];
    corner[0] = '0;
    corner[1] = 1;
    corner[2] = ALL_ONES;
    corner[3] = TOP_BIT;
    corner[4] = ~TOP_BIT;
    roll       = $urandom_range(0, 99);
    w.dividend = $urandom;
    w.divisor  = $urandom;
    if (roll < 25) begin
      // Same pair as the last word: a cache hit.
      w = last_offered;
    end else if (roll < 33) begin
      w.divisor = '0;
    end else if (roll < 45) begin
      w.divisor = $urandom_range(1, 15);
    end else if (roll < 55) begin
      w.divisor = 1 << $urandom_range(0, DW - 1);
    end else if (roll < 63) begin
      // Dividend below the divisor: zero quotient.
      w.divisor  = w.divisor | 1;
      w.dividend = $urandom_range(0, w.divisor - 1);
    end else if (roll < 68) begin
      w.dividend = w.divisor;
    end else if (roll < 80) begin
      w.dividend = corner[$urandom_range(0, 4)];
      w.divisor  = corner[$urandom_range(0, 4)];
    end
    return w;
  endfunction

  // Offer one word and wait until the block takes it. The expectation is
  // queued at the edge of acceptance, so the queue order is the order in
  // which the block saw the words. When no gap is drawn, valid stays high
  // and only the payload changes.
  task automatic offer_word(input rdc_pkg::req_t w, input logic known,
                            input rdc_pkg::rsp_t want);
    int            gap;
    rdc_pkg::rsp_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_division(w);
    pending_results.push_back(known ? want : predicted);
    last_offered = w;
    words_accepted++;
    if (w.divisor == '0) zero_divisors++;
  endtask

  // Result side. A word counts as taken at an edge where valid is high and
  // stall is low; it is checked field by field against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && req_valid && req_stall) input_held_cycles++;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result word: q=%h r=%h hit=%b", rsp.quotient,
                   rsp.remainder, rsp.cache_hit);
      end else begin
        automatic rdc_pkg::rsp_t want = pending_results.pop_front();
        if (rsp.quotient !== want.quotient || rsp.remainder !== want.remainder ||
            rsp.cache_hit !== want.cache_hit) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result %0d mismatch: expected q=%h r=%h hit=%b, got q=%h r=%h hit=%b",
                     results_seen, want.quotient, want.remainder, want.cache_hit,
                     rsp.quotient, rsp.remainder, rsp.cache_hit);
        end
        if (rsp.cache_hit === 1'b1) hits_seen++;
      end
    end
  end

  // Receiver stall. Stretches of no stall, light stall, heavy stall and rare
  // long stalls alternate. Once, early in the random part, the receiver
  // holds off for a long stretch while the sender keeps offering words, so
  // the block fills up and has to stall its input.
  initial begin
    int  mode;
    int  run;
    int  held;
    bit  hold_done;
    rsp_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && words_accepted >= HOLD_AFTER) begin
        rsp_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 120);
      repeat (run) begin
        case (mode)
          0: begin
            rsp_stall <= 1'b0;
            @(posedge clk);
          end
          1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            @(posedge clk);
          end
          2: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
            @(posedge clk);
          end
          default: begin
            if ($urandom_range(0, 30) == 0) begin
              rsp_stall <= 1'b1;
              repeat ($urandom_range(10, 40)) @(posedge clk);
            end else begin
              rsp_stall <= ($urandom_range(0, 7) == 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // Main sequence: reset, the directed table, the random stream, the drain
  // and the verdict.
  initial begin
    dir_row_t      rows[$];
    rdc_pkg::rsp_t no_result;
    int            k;
    rst              = 1'b1;
    req_valid        = 1'b0;
    req              = '0;
    cached_dividend  = '0;
    cached_divisor   = '0;
    cached_quotient  = '0;
    cached_remainder = '0;
    last_offered     = '0;
    no_result        = '0;
    sender_quiet     = 1'b1;
    mismatches       = 0;
    results_seen     = 0;
    hits_seen        = 0;
    zero_divisors    = 0;
    words_accepted   = 0;
    input_held_cycles = 0;

    // Right after reset the cache holds 0/0 with zero results, so 0/0 hits.
    rows.push_back(dir_row(1'b1, '0, '0, '0, '0, 1'b1));
    rows.push_back(dir_row(1'b1, '0, '0, '0, '0, 1'b1));
    rows.push_back(dir_row(1'b1, ALL_ONES, 1, ALL_ONES, '0, 1'b0));
    rows.push_back(dir_row(1'b1, ALL_ONES, 1, ALL_ONES, '0, 1'b1));
    rows.push_back(dir_row(1'b1, ALL_ONES, ALL_ONES, 1, '0, 1'b0));
    rows.push_back(dir_row(1'b1, '0, ALL_ONES, '0, '0, 1'b0));
    // Zero divisor: all-ones quotient, the dividend comes back as remainder.
    rows.push_back(dir_row(1'b1, 5, '0, ALL_ONES, 5, 1'b0));
    // Once the cache has moved on, 0/0 is an ordinary zero-divisor miss.
    rows.push_back(dir_row(1'b1, '0, '0, ALL_ONES, '0, 1'b0));
    rows.push_back(dir_row(1'b1, ALL_ONES, '0, ALL_ONES, ALL_ONES, 1'b0));
    rows.push_back(dir_row(1'b1, ALL_ONES, '0, ALL_ONES, ALL_ONES, 1'b1));
    // Divisors with the top bit set.
    rows.push_back(dir_row(1'b1, TOP_BIT, TOP_BIT | 1, '0, TOP_BIT, 1'b0));
    rows.push_back(dir_row(1'b1, ALL_ONES, TOP_BIT, 1, ~TOP_BIT, 1'b0));
    rows.push_back(dir_row(1'b1, 7, 7, 1, '0, 1'b0));
    rows.push_back(dir_row(1'b1, 1, 2, '0, 1, 1'b0));
    rows.push_back(dir_row(1'b0, 32'hDEAD_BEEF, 32'h0000_1234, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'h1234_5678, 32'h0000_9ABC, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'hFFFF_FFFE, 3, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'hFFFF_FFFE, 3, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, TOP_BIT, 3, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'hFEDC_BA98, 32'h0000_FFFF, '0, '0, 1'b0));
    rows.push_back(dir_row(1'b0, 32'h0F0F_0F0F, 32'hC000_0001, '0, '0, 1'b0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The table goes in without sender gaps at first, then with them.
    for (k = 0; k < rows.size(); k++) begin
      if (k == rows.size() / 2) sender_quiet = 1'b0;
      offer_word(rows[k].stim, rows[k].known, rows[k].want);
    end

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 40 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
      offer_word(random_operands(), 1'b0, no_result);
    end
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_results.size();

    $display("Checked %0d result words from %0d requests: %0d cache hits, %0d zero divisors.",
             results_seen, words_accepted, hits_seen, zero_divisors);
    $display("Input was held off for %0d cycles; %0d failures in %0d cycles.",
             input_held_cycles, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rdc_pkg.sv
rtl/rdc_datapath.sv
rtl/rdc_ctrl.sv
rtl/restoring_divider_with_result_cache_top.sv
test/tb_restoring_divider_with_result_cache_top.sv
